@@ hdl/wndm_pkg.sv @@
`timescale 1ns / 1ps

package wndm_pkg;

	localparam int INPUT_BITS   = 32;
	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;

	localparam int TABLE_LEN = 24;
	localparam int NSTEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int STEP_W    = $clog2(TABLE_LEN);

	// Datapath widths: x and y grow by the CORDIC gain, angles use pi = 2^31.
	localparam int XW    = INPUT_BITS + 4;
	localparam int ZW    = 34;
	localparam int KZ_W  = INPUT_BITS + 1;
	localparam int AUX_W = (KZ_W + 1 > ANGLE_BITS + 1) ? KZ_W + 1 : ANGLE_BITS + 1;

	localparam int          GAIN_W   = 16;
	localparam logic [15:0] GAIN_INV = 16'd39797;
	localparam int          PROD_W   = XW - 1 + GAIN_W;

	localparam int IN_RAW_W     = 3 * INPUT_BITS;
	localparam int IN_TDATA_W   = ((IN_RAW_W + 7) / 8) * 8;
	localparam int OUT_RAW_W    = 2 * ANGLE_BITS - 1;
	localparam int OUT_TDATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

	localparam logic signed [ZW-1:0] Z_PI       = {{(ZW-32){1'b0}}, 1'b1, 31'b0};
	localparam logic signed [ZW-1:0] Z_HALF_PI  = {{(ZW-31){1'b0}}, 1'b1, 30'b0};
	localparam logic [31:0]          ANGLE_RND  = 32'd1 << (31 - ANGLE_BITS);

	localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic [AUX_W-1:0]     aux;
	} cord_t;

	function automatic logic signed [ZW-1:0] atan_val(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		v = (32'(i) < TABLE_LEN) ? ATAN_TAB[i] : 32'd0;
		return signed'(ZW'(v));
	endfunction

	function automatic logic [ANGLE_BITS-1:0] angle_out(input logic [ZW-1:0] z);
		logic [31:0] w;
		w = z[31:0] + ANGLE_RND;
		return w[31 -: ANGLE_BITS];
	endfunction

endpackage

@@ hdl/wndm_cell.sv @@
`timescale 1ns / 1ps

module wndm_cell import wndm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [STEP_W-1:0] step,
	input  logic              in_valid,
	input  cord_t             in_data,
	output logic              out_valid,
	output cord_t             out_data
);

	cord_t nxt;

	always_comb begin
		nxt = in_data;
		if (!in_data.y[XW-1]) begin
			nxt.x = in_data.x + (in_data.y >>> step);
			nxt.y = in_data.y - (in_data.x >>> step);
			nxt.z = in_data.z + atan_val(step);
		end else begin
			nxt.x = in_data.x - (in_data.y >>> step);
			nxt.y = in_data.y + (in_data.x >>> step);
			nxt.z = in_data.z - atan_val(step);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

@@ hdl/wndm_gain.sv @@
`timescale 1ns / 1ps

module wndm_gain import wndm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  cord_t in_data,
	output logic  out_valid,
	output cord_t out_data
);

	logic [XW-2:0]         mag;
	logic                  nz;
	logic [PROD_W-1:0]     prod_s1;
	logic [KZ_W-1:0]       kz_s1;
	logic                  nz_s1;
	logic [ANGLE_BITS-1:0] phi_s1;
	logic                  valid_s1;
	logic [PROD_W-1:0]     rsum;
	logic [XW-2:0]         r;
	logic                  zero;
	cord_t                 nxt;

	assign mag = in_data.x[XW-1] ? '0 : in_data.x[XW-2:0];
	assign nz  = in_data.aux[KZ_W];

	always_comb begin
		rsum = prod_s1 + PROD_W'(32768);
		r    = nz_s1 ? rsum[PROD_W-1:GAIN_W] : '0;
		zero = (r == '0) && (kz_s1 == '0);
		nxt.x   = signed'(XW'(kz_s1));
		nxt.y   = signed'(XW'(r));
		nxt.z   = '0;
		nxt.aux = AUX_W'({zero, phi_s1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= PROD_W'(mag) * PROD_W'(GAIN_INV);
			kz_s1    <= in_data.aux[KZ_W-1:0];
			nz_s1    <= nz;
			phi_s1   <= nz ? angle_out(in_data.z) : '0;
			out_data <= nxt;
		end
	end

endmodule

@@ hdl/wndm_out.sv @@
`timescale 1ns / 1ps

module wndm_out import wndm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  cord_t                  in_data,
	output logic                   en,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata  // polar_angle, azimuth_angle, zero fill
);

	logic signed [ZW-1:0]   zth;
	logic [ANGLE_BITS-1:0]  th_full;
	logic [OUT_TDATA_W-1:0] res;
	logic [OUT_TDATA_W-1:0] skid_q;
	logic                   skid_valid_q;
	logic                   take;
	logic                   arrive;

	always_comb begin
		priority if (in_data.aux[ANGLE_BITS] || in_data.z < 0) begin
			zth = '0;
		end else if (in_data.z > Z_HALF_PI) begin
			zth = Z_HALF_PI;
		end else begin
			zth = in_data.z;
		end
		th_full = angle_out(zth);
		res = OUT_TDATA_W'({in_data.aux[ANGLE_BITS-1:0], th_full[ANGLE_BITS-2:0]});
	end

	assign en     = !skid_valid_q;
	assign take   = !m_tvalid || m_tready;
	assign arrive = in_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				m_tvalid     <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (arrive) begin
			if (take) begin
				m_tvalid <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				m_tdata <= skid_q;
			end
		end else if (arrive) begin
			if (take) begin
				m_tdata <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

endmodule

@@ hdl/wave_normal_direction_means_unit.sv @@
`timescale 1ns / 1ps

// Wave normal direction by the means method. Each input item carries the
// imaginary parts of three off-diagonal spectral entries (kx, ky, kz); each
// output item carries the polar angle (0 to pi/2) and the azimuth (-pi to just
// under pi) in binary radians where 2^(ANGLE_BITS-1) is pi. The block takes one
// item per clock while its skid buffer is empty. Its path runs through
// an input register, a row of NSTEPS CORDIC cells for the azimuth, a two-stage
// gain correction, a second row of NSTEPS cells for the polar angle, and an
// output register backed by a one-item skid buffer.
module wave_normal_direction_means_unit import wndm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // im_yz, im_zx, im_xy, zero fill
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // polar_angle, azimuth_angle, zero fill
);

	logic                      en;
	logic signed [INPUT_BITS:0] kx;
	logic signed [INPUT_BITS:0] ky;
	logic signed [INPUT_BITS:0] kz;
	logic                      flip;
	logic                      neg_x;
	logic signed [INPUT_BITS:0] ax;
	logic signed [INPUT_BITS:0] ay;
	logic [KZ_W-1:0]           kzp;
	logic                      nz;
	cord_t                     start;

	cord_t phi_d [NSTEPS+1];
	logic  phi_v [NSTEPS+1];
	cord_t th_d  [NSTEPS+1];
	logic  th_v  [NSTEPS+1];

	assign s_tready = en;

	always_comb begin
		kx    = {s_tdata[INPUT_BITS-1], s_tdata[INPUT_BITS-1:0]};
		ky    = {s_tdata[2*INPUT_BITS-1], s_tdata[2*INPUT_BITS-1:INPUT_BITS]};
		kz    = {s_tdata[3*INPUT_BITS-1], s_tdata[3*INPUT_BITS-1:2*INPUT_BITS]};
		flip  = kz[INPUT_BITS];
		neg_x = flip ? (kx > 0) : kx[INPUT_BITS];
		ax    = kx[INPUT_BITS] ? -kx : kx;
		ay    = (flip ^ neg_x) ? -ky : ky;
		kzp   = flip ? KZ_W'(-kz) : KZ_W'(kz);
		nz    = (kx != '0) || (ky != '0);
		start.x   = XW'(ax);
		start.y   = XW'(ay);
		start.z   = neg_x ? Z_PI : '0;
		start.aux = AUX_W'({nz, kzp});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phi_v[0] <= 1'b0;
		end else if (en) begin
			phi_v[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_d[0] <= start;
		end
	end

	for (genvar i = 0; i < NSTEPS; i++) begin : g_phi
		wndm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.step      (STEP_W'(i)),
			.in_valid  (phi_v[i]),
			.in_data   (phi_d[i]),
			.out_valid (phi_v[i+1]),
			.out_data  (phi_d[i+1])
		);
	end

	wndm_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (phi_v[NSTEPS]),
		.in_data   (phi_d[NSTEPS]),
		.out_valid (th_v[0]),
		.out_data  (th_d[0])
	);

	for (genvar i = 0; i < NSTEPS; i++) begin : g_theta
		wndm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.step      (STEP_W'(i)),
			.in_valid  (th_v[i]),
			.in_data   (th_d[i]),
			.out_valid (th_v[i+1]),
			.out_data  (th_d[i+1])
		);
	end

	wndm_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (th_v[NSTEPS]),
		.in_data  (th_d[NSTEPS]),
		.en       (en),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
